[design/radio_packet_framer_crc16_assert.svh]
// Assertion macros shared by the framer modules.
// Each macro samples on clk and is disabled while rst is high.
`ifndef RADIO_PACKET_FRAMER_CRC16_ASSERT_SVH
`define RADIO_PACKET_FRAMER_CRC16_ASSERT_SVH

// Same-cycle implication.
`define RPF_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define RPF_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

[design/rpf_pkg.sv]
// Shared constants, command type and CRC-16 byte update for the packet framer.
// No dependencies.
`default_nettype none
package rpf_pkg;

  localparam int unsigned HEADER_BYTES = 6;
  localparam int unsigned MAX_PAYLOAD  = 247;

  localparam logic [7:0]  FILL_BYTE = 8'hAA;
  localparam logic [7:0]  SYNC_HI   = 8'h2D;
  localparam logic [7:0]  SYNC_LO   = 8'hD4;
  localparam logic [7:0]  MAX_LEN   = 8'(MAX_PAYLOAD);
  localparam logic [7:0]  LEN_EXTRA = 8'(HEADER_BYTES + 2);
  localparam logic [15:0] CRC_SEED  = 16'hAAAA;
  localparam logic [15:0] CRC_POLY  = 16'hA001;

  localparam logic OP_START   = 1'b0;
  localparam logic OP_PAYLOAD = 1'b1;

  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QUEUE_AW    = $clog2(QUEUE_DEPTH);
  localparam int unsigned QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

  typedef logic [4:0] pos_t;

  localparam pos_t POS_PRE0     = 5'd0;
  localparam pos_t POS_PRE1     = 5'd1;
  localparam pos_t POS_PRE2     = 5'd2;
  localparam pos_t POS_SYNC_HI  = 5'd3;
  localparam pos_t POS_SYNC_LO  = 5'd4;
  localparam pos_t POS_LEN      = 5'd5;
  localparam pos_t POS_NODE     = 5'd6;
  localparam pos_t POS_RCPT     = 5'd7;
  localparam pos_t POS_FLAGS    = 5'd8;
  localparam pos_t POS_TYPE     = 5'd9;
  localparam pos_t POS_ID_HI    = 5'd10;
  localparam pos_t POS_ID_LO    = 5'd11;
  localparam pos_t POS_PAYLOAD  = 5'd12;
  localparam pos_t POS_CRC_HI   = 5'd13;
  localparam pos_t POS_CRC_LO   = 5'd14;
  localparam pos_t POS_LAST     = 5'd18;

  typedef struct packed {
    logic        kind;
    logic        tail;
    logic [7:0]  len_byte;
    logic [7:0]  recipient;
    logic [7:0]  frame_type;
    logic [7:0]  frame_flags;
    logic [15:0] msg_id;
    logic [7:0]  payload;
  } cmd_t;

  function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage
`default_nettype wire

[design/rpf_front.sv]
// Front end: accepts input transactions, tracks the open frame and builds commands.
// Depends on rpf_pkg.
`default_nettype none
module rpf_front (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          in_valid,
  output logic               in_ready,
  input  wire logic          op,
  input  wire logic [39:0]   data,
  input  wire logic          queue_full,
  output logic               push,
  output rpf_pkg::cmd_t      push_cmd
);
  import rpf_pkg::*;

  logic [15:0] msg_counter;
  logic [7:0]  remaining;
  logic        frame_open;
  logic        accept;
  logic [7:0]  len_in;
  logic [7:0]  len_clamp;

  assign in_ready  = !queue_full;
  assign accept    = in_valid && in_ready;
  assign len_in    = data[31:24];
  assign len_clamp = (len_in > MAX_LEN) ? MAX_LEN : len_in;
  assign push      = accept && ((op == OP_START) || frame_open);

  always_comb begin
    push_cmd             = '0;
    push_cmd.kind        = op;
    push_cmd.recipient   = data[7:0];
    push_cmd.frame_type  = data[15:8];
    push_cmd.frame_flags = data[23:16];
    push_cmd.len_byte    = len_clamp + LEN_EXTRA;
    push_cmd.msg_id      = msg_counter + 16'd1;
    push_cmd.payload     = data[39:32];
    push_cmd.tail        = (op == OP_START) ? (len_clamp == 8'd0) : (remaining == 8'd1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      msg_counter <= '0;
      remaining   <= '0;
      frame_open  <= 1'b0;
    end else if (accept) begin
      if (op == OP_START) begin
        msg_counter <= msg_counter + 16'd1;
        remaining   <= len_clamp;
        frame_open  <= (len_clamp != 8'd0);
      end else if (frame_open) begin
        remaining  <= remaining - 8'd1;
        frame_open <= (remaining != 8'd1);
      end
    end
  end

endmodule
`default_nettype wire

[design/rpf_queue.sv]
// Command queue between the front end and the byte emitter.
// Depends on rpf_pkg and the assertion macro header.
`default_nettype none
`include "radio_packet_framer_crc16_assert.svh"
module rpf_queue (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           push,
  input  wire rpf_pkg::cmd_t  push_cmd,
  output logic                full,
  input  wire logic           pop,
  output logic                head_valid,
  output rpf_pkg::cmd_t       head_cmd
);
  import rpf_pkg::*;

  cmd_t                mem [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0] wr_ptr;
  logic [QUEUE_AW-1:0] rd_ptr;
  logic [QUEUE_CW-1:0] count;
  logic                do_pop;

  assign full       = (count == QUEUE_CW'(QUEUE_DEPTH));
  assign head_valid = (count != '0);
  assign head_cmd   = mem[rd_ptr];
  assign do_pop     = pop && head_valid;

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      count <= count + QUEUE_CW'(push) - QUEUE_CW'(do_pop);
    end
  end

  `RPF_ASSERT_IMP(a_queue_bound, 1'b1, count <= QUEUE_CW'(QUEUE_DEPTH), "queue count overflow")
  `RPF_ASSERT_NXT(a_queue_fill, push && !do_pop, count != '0, "push lost")
  `RPF_ASSERT_IMP(a_no_push_full, full, !push, "push while full")

endmodule
`default_nettype wire

[design/rpf_back.sv]
// Back end: walks each command through frame byte positions, runs the CRC, drives output.
// Depends on rpf_pkg and the assertion macro header.
`default_nettype none
`include "radio_packet_framer_crc16_assert.svh"
module rpf_back (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic [7:0]     node_id,
  input  wire logic           head_valid,
  input  wire rpf_pkg::cmd_t  head_cmd,
  output logic                pop,
  output logic                m_axis_tvalid,
  input  wire logic           m_axis_tready,
  output logic [7:0]          m_axis_tdata,   // [7:0] tx_byte
  output logic                m_axis_tlast,
  output logic                m_axis_tuser    // [0] frame_end
);
  import rpf_pkg::*;

  logic        active;
  cmd_t        cur_cmd;
  pos_t        cur_pos;
  logic [15:0] crc;

  cmd_t        sel_cmd;
  pos_t        sel_pos;
  pos_t        pos_next;
  logic        have;
  logic        adv;
  logic        fire;
  logic        run_end;
  logic [7:0]  out_byte;
  logic [15:0] crc_in;
  logic [15:0] crc_next;

  assign have    = active || head_valid;
  assign sel_cmd = active ? cur_cmd : head_cmd;
  assign sel_pos = active ? cur_pos : ((head_cmd.kind == OP_START) ? POS_PRE0 : POS_PAYLOAD);
  assign adv     = !m_axis_tvalid || m_axis_tready;
  assign fire    = adv && have;
  assign pop     = fire && !active;

  assign run_end  = (sel_pos == POS_LAST) ||
                    (((sel_pos == POS_ID_LO) || (sel_pos == POS_PAYLOAD)) && !sel_cmd.tail);
  assign pos_next = (sel_pos == POS_ID_LO) ? POS_CRC_HI : (sel_pos + 5'd1);
  assign crc_in   = (sel_pos == POS_LEN) ? CRC_SEED : crc;
  assign crc_next = crc_byte(crc_in, out_byte);

  always_comb begin
    unique case (sel_pos)
      POS_SYNC_HI: out_byte = SYNC_HI;
      POS_SYNC_LO: out_byte = SYNC_LO;
      POS_LEN:     out_byte = sel_cmd.len_byte;
      POS_NODE:    out_byte = node_id;
      POS_RCPT:    out_byte = sel_cmd.recipient;
      POS_FLAGS:   out_byte = sel_cmd.frame_flags;
      POS_TYPE:    out_byte = sel_cmd.frame_type;
      POS_ID_HI:   out_byte = sel_cmd.msg_id[15:8];
      POS_ID_LO:   out_byte = sel_cmd.msg_id[7:0];
      POS_PAYLOAD: out_byte = sel_cmd.payload;
      POS_CRC_HI:  out_byte = crc[15:8];
      POS_CRC_LO:  out_byte = crc[7:0];
      default:     out_byte = FILL_BYTE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      cur_cmd      <= sel_cmd;
      cur_pos      <= pos_next;
      m_axis_tdata <= out_byte;
      m_axis_tlast <= run_end;
      m_axis_tuser <= (sel_pos == POS_LAST);
      if ((sel_pos >= POS_LEN) && (sel_pos <= POS_PAYLOAD)) begin
        crc <= crc_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active        <= 1'b0;
      m_axis_tvalid <= 1'b0;
    end else begin
      if (adv) begin
        m_axis_tvalid <= have;
      end
      if (fire) begin
        active <= !run_end;
      end
    end
  end

  `RPF_ASSERT_IMP(a_end_is_last, m_axis_tvalid && m_axis_tuser, m_axis_tlast, "frame end not last")
  `RPF_ASSERT_IMP(a_active_pos, active, (cur_pos != POS_PRE0) && (cur_pos <= POS_LAST), "bad position")
  `RPF_ASSERT_NXT(a_run_done, fire && run_end, !active, "run did not close")

endmodule
`default_nettype wire

[design/radio_packet_framer_crc16.sv]
// Radio packet framer with CRC-16: one byte per output transaction. A start transaction
// (tuser 0) yields 12 header bytes (preamble, sync, length, node, recipient, flags, type,
// message id), or 18 bytes including CRC and trailer when its length is zero. A payload
// transaction (tuser 1) yields its byte, plus CRC and four trailer bytes on the last one;
// payload with no open frame is dropped. Input is taken every cycle while the 4-entry
// command queue has room; while m_axis_tready holds, the back-end emitter produces one
// byte per cycle, so throughput is one output byte and one payload item per cycle.
// Depends on rpf_pkg, rpf_front, rpf_queue and rpf_back.
`default_nettype none
module radio_packet_framer_crc16 (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_wr_en,
  input  wire logic [7:0]  cfg_wr_data,    // node_id
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [39:0] s_axis_tdata,   // recipient, frame_type, frame_flags,
                                           // payload_length, payload_byte
  input  wire logic        s_axis_tuser,   // [0] operation
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [7:0]       m_axis_tdata,   // [7:0] tx_byte
  output logic             m_axis_tlast,   // run_last
  output logic             m_axis_tuser    // [0] frame_end
);
  import rpf_pkg::*;

  logic [7:0] node_id;
  logic       queue_full;
  logic       push;
  cmd_t       push_cmd;
  logic       pop;
  logic       head_valid;
  cmd_t       head_cmd;

  always_ff @(posedge clk) begin
    if (rst) begin
      node_id <= '0;
    end else if (cfg_wr_en) begin
      node_id <= cfg_wr_data;
    end
  end

  rpf_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (s_axis_tvalid),
    .in_ready   (s_axis_tready),
    .op         (s_axis_tuser),
    .data       (s_axis_tdata),
    .queue_full (queue_full),
    .push       (push),
    .push_cmd   (push_cmd)
  );

  rpf_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_cmd   (push_cmd),
    .full       (queue_full),
    .pop        (pop),
    .head_valid (head_valid),
    .head_cmd   (head_cmd)
  );

  rpf_back u_back (
    .clk           (clk),
    .rst           (rst),
    .node_id       (node_id),
    .head_valid    (head_valid),
    .head_cmd      (head_cmd),
    .pop           (pop),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser)
  );

endmodule
`default_nettype wire

[tb/radio_packet_framer_crc16_tb.sv]
// Self-checking testbench for radio_packet_framer_crc16: directed rows, then random frames.
// A transaction-level predictor of the frame bytes and CRC checks every output transaction in order.
// Depends on rpf_pkg and radio_packet_framer_crc16.
module radio_packet_framer_crc16_tb;
  import rpf_pkg::*;

  localparam int         WATCHDOG_LIMIT = 1000;
  localparam int         DIRECTED_ROWS  = 20;
  localparam logic [4:0] RUNS_ANY       = 5'd31;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
    logic       fend;
  } tx_beat_t;

  typedef struct packed {
    logic       set_node;
    logic [7:0] node;
    logic       op;
    logic [7:0] rcpt;
    logic [7:0] ftype;
    logic [7:0] flags;
    logic [7:0] len;
    logic [7:0] pay;
    logic [4:0] runs;
  } step_row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_wr_en = 1'b0;
  logic [7:0]  cfg_wr_data = 8'h00;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [39:0] s_axis_tdata = '0;
  logic        s_axis_tuser = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [7:0]  m_axis_tdata;
  logic        m_axis_tlast;
  logic        m_axis_tuser;

  logic [4:0]  typed_runs = RUNS_ANY;

  logic [7:0]  node_sel = 8'h00;
  logic [15:0] id_count = 16'h0000;
  logic [15:0] crc_acc = CRC_SEED;
  logic [7:0]  left_count = 8'h00;
  logic        frame_live = 1'b0;
  tx_beat_t    tx_expect[$];
  tx_beat_t    got_beat;

  int          fail_count = 0;
  int          idle_cycles = 0;
  int          run_len;
  int          src_pct = 25;
  int          snk_pct = 25;
  int          stall_left = 0;
  int          items = 0;

  radio_packet_framer_crc16 uut (
    .clk          (clk),
    .rst          (rst),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_wr_data  (cfg_wr_data),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast),
    .m_axis_tuser (m_axis_tuser)
  );

  always #4 clk = ~clk;

  function automatic logic [15:0] crc_fold(input logic [15:0] c, input logic [7:0] b);
    logic [15:0] r;
    r = c ^ {8'h00, b};
    repeat (8) r = r[0] ? ({1'b0, r[15:1]} ^ CRC_POLY) : {1'b0, r[15:1]};
    return r;
  endfunction

  function automatic void put_byte(input logic [7:0] b, input logic feed, input logic fend);
    if (feed) crc_acc = crc_fold(crc_acc, b);
    tx_expect.push_back('{data: b, last: 1'b0, fend: fend});
  endfunction

  function automatic void put_tail();
    put_byte(crc_acc[15:8], 1'b0, 1'b0);
    put_byte(crc_acc[7:0], 1'b0, 1'b0);
    repeat (3) put_byte(FILL_BYTE, 1'b0, 1'b0);
    put_byte(FILL_BYTE, 1'b0, 1'b1);
    frame_live = 1'b0;
    left_count = 8'h00;
  endfunction

  function automatic int frame_predict(input logic op, input logic [39:0] d);
    logic [7:0] len;
    int         base;
    tx_beat_t   tail_beat;
    base = tx_expect.size();
    if (op == OP_START) begin
      len = (d[31:24] > MAX_LEN) ? MAX_LEN : d[31:24];
      id_count = id_count + 16'd1;
      crc_acc = CRC_SEED;
      repeat (3) put_byte(FILL_BYTE, 1'b0, 1'b0);
      put_byte(SYNC_HI, 1'b0, 1'b0);
      put_byte(SYNC_LO, 1'b0, 1'b0);
      put_byte(len + LEN_EXTRA, 1'b1, 1'b0);
      put_byte(node_sel, 1'b1, 1'b0);
      put_byte(d[7:0], 1'b1, 1'b0);
      put_byte(d[23:16], 1'b1, 1'b0);
      put_byte(d[15:8], 1'b1, 1'b0);
      put_byte(id_count[15:8], 1'b1, 1'b0);
      put_byte(id_count[7:0], 1'b1, 1'b0);
      left_count = len;
      frame_live = 1'b1;
      if (len == 8'h00) put_tail();
    end else if (frame_live && left_count != 8'h00) begin
      put_byte(d[39:32], 1'b1, 1'b0);
      left_count = left_count - 8'd1;
      if (left_count == 8'h00) put_tail();
    end
    if (tx_expect.size() > base) begin
      tail_beat = tx_expect.pop_back();
      tail_beat.last = 1'b1;
      tx_expect.push_back(tail_beat);
    end
    return tx_expect.size() - base;
  endfunction

  always @(posedge clk) begin
    if (stall_left != 0) begin
      stall_left <= stall_left - 1;
    end else if (snk_pct != 0 && $urandom_range(99) < snk_pct) begin
      m_axis_tready <= 1'b0;
      stall_left <= $urandom_range(0, 10);
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (cfg_wr_en) node_sel = cfg_wr_data;
      if (s_axis_tvalid && s_axis_tready) begin
        run_len = frame_predict(s_axis_tuser, s_axis_tdata);
        if (typed_runs != RUNS_ANY && run_len != typed_runs) begin
          $error("result count: expected %0d, predicted %0d", typed_runs, run_len);
          fail_count++;
        end
      end
      if (m_axis_tvalid && m_axis_tready) begin
        if (tx_expect.size() == 0) begin
          $error("output transaction with nothing expected: tx_byte %h", m_axis_tdata);
          fail_count++;
        end else begin
          got_beat = tx_expect.pop_front();
          if (m_axis_tdata !== got_beat.data) begin
            $error("tx_byte: expected %h, actual %h", got_beat.data, m_axis_tdata);
            fail_count++;
          end
          if (m_axis_tlast !== got_beat.last) begin
            $error("run_last: expected %b, actual %b", got_beat.last, m_axis_tlast);
            fail_count++;
          end
          if (m_axis_tuser !== got_beat.fend) begin
            $error("frame_end: expected %b, actual %b", got_beat.fend, m_axis_tuser);
            fail_count++;
          end
        end
      end
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("radio_packet_framer_crc16 test failed");
        $finish;
      end
    end
  end

  function automatic step_row_t row_at(input int i);
    step_row_t r;
    case (i)
      0:  r = '{1'b0, 8'h00, OP_PAYLOAD, 8'h00, 8'h00, 8'h00, 8'h00, 8'hFF, 5'd0};
      1:  r = '{1'b0, 8'h00, OP_START,   8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 5'd18};
      2:  r = '{1'b0, 8'h00, OP_START,   8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 5'd12};
      3:  r = '{1'b0, 8'h00, OP_PAYLOAD, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h00, 5'd1};
      4:  r = '{1'b0, 8'h00, OP_PAYLOAD, 8'h00, 8'h00, 8'h00, 8'h00, 8'hFF, 5'd1};
      5:  r = '{1'b0, 8'h00, OP_START,   8'h12, 8'h34, 8'h56, 8'h01, 8'h00, 5'd12};
      6:  r = '{1'b0, 8'h00, OP_PAYLOAD, 8'h00, 8'h00, 8'h00, 8'h00, 8'hA5, 5'd7};
      7:  r = '{1'b0, 8'h00, OP_PAYLOAD, 8'hFF, 8'hFF, 8'hFF, 8'h00, 8'h5A, 5'd0};
      8:  r = '{1'b0, 8'h00, OP_START,   8'h80, 8'h01, 8'h7F, 8'hF8, 8'h00, 5'd12};
      9:  r = '{1'b0, 8'h00, OP_START,   8'h01, 8'h80, 8'hFE, 8'hF7, 8'hFF, 5'd12};
      10: r = '{1'b0, 8'h00, OP_PAYLOAD, 8'h00, 8'h00, 8'h00, 8'h00, 8'h7E, 5'd1};
      11: r = '{1'b0, 8'h00, OP_START,   8'h00, 8'hFF, 8'h00, 8'h02, 8'h00, 5'd12};
      12: r = '{1'b0, 8'h00, OP_PAYLOAD, 8'h00, 8'h00, 8'h00, 8'h00, 8'h01, 5'd1};
      13: r = '{1'b0, 8'h00, OP_PAYLOAD, 8'h00, 8'h00, 8'h00, 8'h00, 8'h80, 5'd7};
      14: r = '{1'b0, 8'h00, OP_START,   8'hFF, 8'h00, 8'hFF, 8'h01, 8'h00, 5'd12};
      15: r = '{1'b0, 8'h00, OP_PAYLOAD, 8'h00, 8'h00, 8'h00, 8'h00, 8'hFF, 5'd7};
      16: r = '{1'b1, 8'hFF, OP_START,   8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 5'd18};
      17: r = '{1'b1, 8'h00, OP_START,   8'h11, 8'h22, 8'h33, 8'h00, 8'h00, 5'd18};
      18: r = '{1'b0, 8'h00, OP_START,   8'h44, 8'h55, 8'h66, 8'h01, 8'h00, 5'd12};
      19: r = '{1'b0, 8'h00, OP_PAYLOAD, 8'h00, 8'h00, 8'h00, 8'h00, 8'hC3, 5'd7};
      default: r = '0;
    endcase
    return r;
  endfunction

  task automatic push_item(input logic op, input logic [39:0] d, input logic [4:0] runs);
    if (src_pct != 0 && $urandom_range(99) < src_pct) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= d;
    typed_runs    <= runs;
    do @(posedge clk); while (!s_axis_tready);
  endtask

  task automatic settle();
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (tx_expect.size() != 0) @(posedge clk);
    repeat (32) @(posedge clk);
  endtask

  task automatic load_node(input logic [7:0] v);
    settle();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  task automatic random_frame();
    logic [39:0] d;
    int          eff;
    int          n;
    d = 40'({$urandom(), $urandom()});
    d[31:24] = ($urandom_range(0, 19) == 0) ? 8'($urandom_range(0, 255))
                                            : 8'($urandom_range(0, 12));
    eff = (d[31:24] > MAX_LEN) ? int'(MAX_LEN) : int'(d[31:24]);
    push_item(OP_START, d, RUNS_ANY);
    n = ($urandom_range(0, 4) == 0) ? $urandom_range(0, eff) : eff;
    repeat (n) push_item(OP_PAYLOAD, 40'({$urandom(), $urandom()}), RUNS_ANY);
    items += 1 + n;
    if ($urandom_range(0, 3) == 0)
      push_item(OP_PAYLOAD, 40'({$urandom(), $urandom()}), RUNS_ANY);
  endtask

  initial begin
    step_row_t row;
    int        target;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    for (int i = 0; i < DIRECTED_ROWS; i++) begin
      row = row_at(i);
      if (row.set_node) load_node(row.node);
      push_item(row.op, {row.pay, row.len, row.flags, row.ftype, row.rcpt}, row.runs);
    end
    for (int ph = 0; ph < 3; ph++) begin
      load_node(8'($urandom_range(0, 255)));
      src_pct = (ph == 2) ? 0 : 30;
      snk_pct = (ph == 2) ? 0 : 30;
      target = items + 72;
      while (items < target) random_frame();
    end
    settle();
    if (fail_count == 0)
      $display("radio_packet_framer_crc16 test passed");
    else
      $display("radio_packet_framer_crc16 test failed");
    $finish;
  end

endmodule
